// File: hw/rtl/linear_move_segmenter_unit_macros.svh
// assertion macros for the linear move segmenter checker
`ifndef LINEAR_MOVE_SEGMENTER_UNIT_MACROS_SVH
`define LINEAR_MOVE_SEGMENTER_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, quiet in reset
`define LMS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lms assertion failed");

// next-cycle implication, clocked on aclk, quiet in reset
`define LMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lms assertion failed");

`endif

// File: hw/rtl/lms_pkg.sv
// types, widths and codes shared by the linear move segmenter files
package lms_pkg;

    localparam int COORD_BITS  = 16;
    localparam int ROUTE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * ROUTE_BITS;
    localparam int DIV_STEPS   = PROD_BITS / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int STEP_BITS   = 15;
    localparam int TICK_BITS   = 16;
    localparam int TIME_BITS   = 32;
    localparam int MODE_BITS   = 2;
    localparam int OP_BITS     = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam int IN_BITS     = 2 * COORD_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = MODE_BITS + 4 * ROUTE_BITS + 2 * TIME_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_SET_POS = 3'd0,
        OP_MOVE    = 3'd1,
        OP_STEP    = 3'd2,
        OP_HOME    = 3'd3,
        OP_DELAY   = 3'd4
    } op_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_MOVE  = 2'd0,
        MODE_HOME  = 2'd1,
        MODE_DELAY = 2'd2
    } mode_t;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_TOTAL  = 1'd1;

    localparam logic [STEP_BITS-1:0] STEP_LENGTH_RESET = 15'd100;
    localparam logic [TICK_BITS-1:0] TICK_TOTAL_RESET  = 16'd1000;

endpackage

// File: hw/rtl/linear_move_segmenter_unit.sv
// linear move segmenter: splits straight moves into motion blocks
//
// channel | direction | tdata                                  | tuser | tlast
// s_      | in        | target_x, target_y                     | op    | -
// m_      | out       | block_mode, step_dx, step_dy, time_x,  | -     | route_done
//         |           | time_y, route_pos_x, route_pos_y       |       |
// cfg_    | in        | write enable, register index, data     | -     | -
//
// set position, move and ignored codes finish in ST_IDLE, home and delay go to ST_OUT
// a step runs ST_MUL, ST_DIV1, ST_FIX, ST_TIME, ST_DIV2, ST_MULX, ST_MULY, ST_OUT,
// skipping from ST_TIME to ST_OUT when one axis is still, so the shared 2-bit-per-cycle
// restoring divider runs up to twice; a route's final block needs at most the unit division
// reset is synchronous; no item is taken until the previous result sits in the
// output register, which holds a transaction while m_tready is low
module linear_move_segmenter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lms_pkg::IN_TDATA_W-1:0]      s_tdata,   // target_x, target_y
    input  logic [lms_pkg::OP_BITS-1:0]         s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lms_pkg::OUT_TDATA_W-1:0]     m_tdata,   // block_mode, step_dx, step_dy,
                                                           // time_x, time_y, route_pos_x,
                                                           // route_pos_y
    output logic                                m_tlast,   // route_done
    input  logic                                cfg_wr_en,
    input  logic [lms_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lms_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CB = lms_pkg::COORD_BITS;
    localparam int RB = lms_pkg::ROUTE_BITS;
    localparam int PB = lms_pkg::PROD_BITS;
    localparam int TB = lms_pkg::TICK_BITS;
    localparam int WB = lms_pkg::TIME_BITS;
    localparam int TPW = TB + RB;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DIV1, ST_FIX, ST_TIME, ST_DIV2, ST_MULX, ST_MULY, ST_OUT
    } state_t;

    function automatic logic [RB-1:0] mag_r(input logic signed [RB-1:0] v);
        return v[RB-1] ? RB'(-v) : RB'(v);
    endfunction

    state_t                                state_reg, state_next;
    logic [lms_pkg::STEP_BITS-1:0]         step_len_reg, step_len_next;
    logic [TB-1:0]                         tick_reg, tick_next;
    logic                                  active_reg, active_next;
    logic                                  longer_x_reg, longer_x_next;
    logic signed [RB-1:0]                  goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic signed [RB-1:0]                  done_x_reg, done_x_next, done_y_reg, done_y_next;
    logic signed [CB-1:0]                  last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic signed [RB-1:0]                  odx_reg, odx_next, ody_reg, ody_next;
    logic                                  fin_reg, fin_next;
    lms_pkg::mode_t                        mode_reg, mode_next;
    logic [WB-1:0]                         tx_reg, tx_next, ty_reg, ty_next;
    logic                                  neg_reg, neg_next;
    logic [RB-1:0]                         div_rem_reg, div_rem_next;
    logic [PB-1:0]                         div_quo_reg, div_quo_next;
    logic [RB-1:0]                         div_den_reg, div_den_next;
    logic [lms_pkg::DIV_CNT_W-1:0]         div_cnt_reg, div_cnt_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic                                  m_tlast_reg, m_tlast_next;
    logic [lms_pkg::OUT_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    logic signed [CB-1:0]                  in_x, in_y;
    lms_pkg::op_t                          in_op;
    logic                                  in_acc;
    logic signed [RB-1:0]                  mv_gx, mv_gy;
    logic signed [RB-1:0]                  goal_l, done_l, goal_o, done_o, step_v;
    logic signed [RB:0]                    rem_l;
    logic [RB:0]                           rem_mag;
    logic [RB:0]                           dv_r1, dv_s1, dv_r2, dv_s2;
    logic                                  dv_b1, dv_b2;
    logic [RB-1:0]                         qmag;
    logic signed [RB-1:0]                  qval;
    logic [TPW-1:0]                        tprod;
    logic [WB-1:0]                         tsat;
    logic signed [RB-1:0]                  pos_x, pos_y;

    assign in_x   = s_tdata[CB-1:0];
    assign in_y   = s_tdata[2*CB-1:CB];
    assign in_op  = lms_pkg::op_t'(s_tuser);
    assign in_acc = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        mv_gx   = RB'({in_x[CB-1], in_x}) - RB'({last_x_reg[CB-1], last_x_reg});
        mv_gy   = RB'({in_y[CB-1], in_y}) - RB'({last_y_reg[CB-1], last_y_reg});
        goal_l  = longer_x_reg ? goal_x_reg : goal_y_reg;
        done_l  = longer_x_reg ? done_x_reg : done_y_reg;
        goal_o  = longer_x_reg ? goal_y_reg : goal_x_reg;
        done_o  = longer_x_reg ? done_y_reg : done_x_reg;
        rem_l   = {goal_l[RB-1], goal_l} - {done_l[RB-1], done_l};
        rem_mag = rem_l[RB] ? (RB+1)'(-rem_l) : (RB+1)'(rem_l);
        step_v  = (!goal_l[RB-1] && goal_l != '0) ? RB'(step_len_reg) : RB'(-step_len_reg);

        dv_r1 = {div_rem_reg, div_quo_reg[PB-1]};
        dv_b1 = dv_r1 >= {1'b0, div_den_reg};
        dv_s1 = dv_b1 ? dv_r1 - {1'b0, div_den_reg} : dv_r1;
        dv_r2 = {dv_s1[RB-1:0], div_quo_reg[PB-2]};
        dv_b2 = dv_r2 >= {1'b0, div_den_reg};
        dv_s2 = dv_b2 ? dv_r2 - {1'b0, div_den_reg} : dv_r2;

        qmag = (div_den_reg == '0) ? '0 : div_quo_reg[RB-1:0];
        qval = neg_reg ? RB'(-qmag) : RB'(qmag);

        tprod = div_quo_reg[TB-1:0] * ((state_reg == ST_MULX) ? mag_r(ody_reg) : mag_r(odx_reg));
        tsat  = (64'(tprod) > 64'hFFFF_FFFF) ? '1 : WB'(tprod);

        pos_x = (mode_reg == lms_pkg::MODE_MOVE) ? done_x_reg : '0;
        pos_y = (mode_reg == lms_pkg::MODE_MOVE) ? done_y_reg : '0;
    end

    always_comb begin
        state_next    = state_reg;
        step_len_next = step_len_reg;
        tick_next     = tick_reg;
        active_next   = active_reg;
        longer_x_next = longer_x_reg;
        goal_x_next   = goal_x_reg;
        goal_y_next   = goal_y_reg;
        done_x_next   = done_x_reg;
        done_y_next   = done_y_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        odx_next      = odx_reg;
        ody_next      = ody_reg;
        fin_next      = fin_reg;
        mode_next     = mode_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        neg_next      = neg_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                lms_pkg::REG_STEP_LENGTH: step_len_next = cfg_wdata[lms_pkg::STEP_BITS-1:0];
                lms_pkg::REG_TICK_TOTAL:  tick_next     = cfg_wdata[TB-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op) inside
                        lms_pkg::OP_SET_POS: begin
                            last_x_next = in_x;
                            last_y_next = in_y;
                        end
                        lms_pkg::OP_MOVE: begin
                            goal_x_next   = mv_gx;
                            goal_y_next   = mv_gy;
                            done_x_next   = '0;
                            done_y_next   = '0;
                            last_x_next   = in_x;
                            last_y_next   = in_y;
                            longer_x_next = mag_r(mv_gx) > mag_r(mv_gy);
                            active_next   = 1'b1;
                        end
                        lms_pkg::OP_HOME, lms_pkg::OP_DELAY: begin
                            mode_next  = (in_op == lms_pkg::OP_HOME) ? lms_pkg::MODE_HOME
                                                                     : lms_pkg::MODE_DELAY;
                            odx_next   = (in_op == lms_pkg::OP_HOME) ? '0
                                                                     : RB'({in_x[CB-1], in_x});
                            ody_next   = '0;
                            tx_next    = '0;
                            ty_next    = '0;
                            fin_next   = 1'b0;
                            state_next = ST_OUT;
                        end
                        lms_pkg::OP_STEP: begin
                            if (active_reg) begin
                                mode_next = lms_pkg::MODE_MOVE;
                                if (32'(rem_mag) > 32'(step_len_reg)) begin
                                    fin_next = 1'b0;
                                    if (longer_x_reg) begin
                                        odx_next    = step_v;
                                        done_x_next = done_x_reg + step_v;
                                    end else begin
                                        ody_next    = step_v;
                                        done_y_next = done_y_reg + step_v;
                                    end
                                    state_next = ST_MUL;
                                end else begin
                                    odx_next    = goal_x_reg - done_x_reg;
                                    ody_next    = goal_y_reg - done_y_reg;
                                    done_x_next = goal_x_reg;
                                    done_y_next = goal_y_reg;
                                    active_next = 1'b0;
                                    fin_next    = 1'b1;
                                    state_next  = ST_TIME;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                div_quo_next = PB'(mag_r(goal_o)) * PB'(mag_r(done_l));
                neg_next     = goal_o[RB-1] ^ done_l[RB-1] ^ goal_l[RB-1];
                div_den_next = mag_r(goal_l);
                div_rem_next = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV1;
            end
            ST_DIV1, ST_DIV2: begin
                div_rem_next = dv_s2[RB-1:0];
                div_quo_next = {div_quo_reg[PB-3:0], dv_b1, dv_b2};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == lms_pkg::DIV_CNT_W'(lms_pkg::DIV_STEPS - 1)) begin
                    state_next = (state_reg == ST_DIV1) ? ST_FIX : ST_MULX;
                end
            end
            ST_FIX: begin
                if (longer_x_reg) begin
                    ody_next    = qval - done_o;
                    done_y_next = qval;
                end else begin
                    odx_next    = qval - done_o;
                    done_x_next = qval;
                end
                state_next = ST_TIME;
            end
            ST_TIME: begin
                if (ody_reg == '0) begin
                    tx_next    = WB'(tick_reg);
                    ty_next    = '0;
                    state_next = ST_OUT;
                end else if (odx_reg == '0) begin
                    tx_next    = '0;
                    ty_next    = WB'(tick_reg);
                    state_next = ST_OUT;
                end else begin
                    div_quo_next = PB'(tick_reg);
                    div_den_next = longer_x_reg ? mag_r(ody_reg) : mag_r(odx_reg);
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV2;
                end
            end
            ST_MULX: begin
                tx_next    = tsat;
                state_next = ST_MULY;
            end
            ST_MULY: begin
                ty_next    = tsat;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = fin_reg;
                    m_tdata_next  = lms_pkg::OUT_TDATA_W'({pos_y, pos_x, ty_reg, tx_reg,
                                                           ody_reg, odx_reg, mode_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_len_reg <= lms_pkg::STEP_LENGTH_RESET;
            tick_reg     <= lms_pkg::TICK_TOTAL_RESET;
            active_reg   <= 1'b0;
            longer_x_reg <= 1'b0;
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            done_x_reg   <= '0;
            done_y_reg   <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_len_reg <= step_len_next;
            tick_reg     <= tick_next;
            active_reg   <= active_next;
            longer_x_reg <= longer_x_next;
            goal_x_reg   <= goal_x_next;
            goal_y_reg   <= goal_y_next;
            done_x_reg   <= done_x_next;
            done_y_reg   <= done_y_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        odx_reg     <= odx_next;
        ody_reg     <= ody_next;
        fin_reg     <= fin_next;
        mode_reg    <= mode_next;
        tx_reg      <= tx_next;
        ty_reg      <= ty_next;
        neg_reg     <= neg_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: hw/rtl/lms_checker.sv
// port checker for the linear move segmenter, bound to the top level
`include "linear_move_segmenter_unit_macros.svh"

module lms_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lms_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    localparam int RB = lms_pkg::ROUTE_BITS;
    localparam int MB = lms_pkg::MODE_BITS;
    localparam int OB = lms_pkg::OUT_BITS;

    logic move_blk;
    logic home_blk;
    logic tail_zero;
    logic dx_zero;

    assign move_blk  = (m_tdata[MB-1:0] == lms_pkg::MODE_MOVE);
    assign home_blk  = (m_tdata[MB-1:0] == lms_pkg::MODE_HOME);
    assign tail_zero = (m_tdata[OB-1:MB+RB] == '0);
    assign dx_zero   = (m_tdata[MB+RB-1:MB] == '0);

    `LMS_ASSERT_NEXT(a_valid_held, m_tvalid && !m_tready, m_tvalid)
    `LMS_ASSERT_NEXT(a_data_held, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    `LMS_ASSERT_IMPL(a_done_only_move, m_tvalid && m_tlast, move_blk)
    `LMS_ASSERT_IMPL(a_plain_blk_zero, m_tvalid && !move_blk, tail_zero && (!home_blk || dx_zero))

endmodule

bind linear_move_segmenter_unit lms_checker u_lms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
